>>> hdl/dwwf_pkg.sv
// Package with the command codes, status codes and item types of the display window write framer.
package dwwf_pkg;

  localparam int unsigned CoordW = 9;
  localparam int unsigned AddrW = 11;
  localparam int unsigned SeqW = 4;

  localparam logic [1:0] OP_RECT = 2'd0;
  localparam logic [1:0] OP_PIXEL = 2'd1;
  localparam logic [1:0] OP_FLIP = 2'd2;

  localparam logic [7:0] CMD_COLUMN = 8'h2A;
  localparam logic [7:0] CMD_ROW = 8'h2B;
  localparam logic [7:0] CMD_MEMWRITE = 8'h2C;
  localparam logic [7:0] CMD_ORIENT = 8'h36;
  localparam logic [7:0] BYTE_MASK = 8'hFF;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_BAD_RECT = 2'd1;
  localparam logic [1:0] ST_NO_WRITE = 2'd2;
  localparam logic [1:0] ST_WRITE_OPEN = 2'd3;

  localparam logic [3:0] REG_FRAME_WIDTH = 4'd0;
  localparam logic [3:0] REG_FRAME_HEIGHT = 4'd1;
  localparam logic [3:0] REG_COL_OFS_NORMAL = 4'd2;
  localparam logic [3:0] REG_ROW_OFS_NORMAL = 4'd3;
  localparam logic [3:0] REG_COL_OFS_FLIPPED = 4'd4;
  localparam logic [3:0] REG_ROW_OFS_FLIPPED = 4'd5;
  localparam logic [3:0] REG_ORIENT_NORMAL = 4'd6;
  localparam logic [3:0] REG_ORIENT_FLIPPED = 4'd7;

  localparam logic [SeqW-1:0] SEQ_COL_CMD = 4'd0;
  localparam logic [SeqW-1:0] SEQ_COL_S_HI = 4'd1;
  localparam logic [SeqW-1:0] SEQ_COL_S_LO = 4'd2;
  localparam logic [SeqW-1:0] SEQ_COL_E_HI = 4'd3;
  localparam logic [SeqW-1:0] SEQ_COL_E_LO = 4'd4;
  localparam logic [SeqW-1:0] SEQ_ROW_CMD = 4'd5;
  localparam logic [SeqW-1:0] SEQ_ROW_S_HI = 4'd6;
  localparam logic [SeqW-1:0] SEQ_ROW_S_LO = 4'd7;
  localparam logic [SeqW-1:0] SEQ_ROW_E_HI = 4'd8;
  localparam logic [SeqW-1:0] SEQ_ROW_E_LO = 4'd9;
  localparam logic [SeqW-1:0] SEQ_MEMWRITE = 4'd10;
  localparam logic [SeqW-1:0] SEQ_FIRST = 4'd0;
  localparam logic [SeqW-1:0] SEQ_SECOND = 4'd1;

  typedef enum logic [1:0] {
    KIND_RECT,
    KIND_PIXEL,
    KIND_FLIP,
    KIND_STATUS
  } kind_t;

  typedef struct packed {
    kind_t           kind;
    logic [SeqW-1:0] last_seq;
    logic [AddrW-1:0] col_start;
    logic [AddrW-1:0] col_end;
    logic [AddrW-1:0] row_start;
    logic [AddrW-1:0] row_end;
    logic [15:0]     color;
    logic            done;
    logic [7:0]      orient;
    logic [1:0]      status;
  } item_t;

endpackage

>>> hdl/display_window_write_framer.sv
// Top level of the display window write framer: item register, byte sequencer and output register.
//
//   Channel  Direction  Transaction carries
//   s_*      in         tuser: op; tdata: rect_x, rect_y, rect_w, rect_h, pixel_color, flip
//   m_*      out        tdata: out_byte, status; tuser: is_data, has_byte, release_panel;
//                       tlast: run_last
//   cfg_*    in         cfg_index: register index; cfg_data: register value
//
// A pixel item gives two bytes, a flip item two, a rectangle eleven, a rejected item one status
// transaction and an unused op none; the output moves one byte per cycle while m_tready is high.
// The next item is taken in the cycle in which the last byte of the current one is loaded.
// Reset loads the register defaults and closes any write; there is no clearing pass.
// A low m_tready holds the output register; while an item is busy it holds the item register and s_tready drops.
module display_window_write_framer
  import dwwf_pkg::*;
#(
  parameter int unsigned MAX_DIM = 320
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // [8:0] rect_x, [17:9] rect_y, [26:18] rect_w, [35:27] rect_h, [51:36] pixel_color,
  // [52] flip, [55:53] zero
  input  logic [55:0] s_tdata,
  // [1:0] op
  input  logic [1:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // [7:0] out_byte, [9:8] status, [15:10] zero
  output logic [15:0] m_tdata,
  // [0] is_data, [1] has_byte, [2] release_panel
  output logic [2:0]  m_tuser,
  output logic        m_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  cfg_index,
  input  logic [8:0]  cfg_data
);

  localparam int unsigned PixW = $clog2(MAX_DIM * MAX_DIM + 1);
  localparam int unsigned DimW = $clog2(MAX_DIM + 1) > CoordW ? $clog2(MAX_DIM + 1) : CoordW;

  logic [CoordW-1:0] frame_width;
  logic [CoordW-1:0] frame_height;
  logic [CoordW-1:0] col_offset_normal;
  logic [CoordW-1:0] row_offset_normal;
  logic [CoordW-1:0] col_offset_flipped;
  logic [CoordW-1:0] row_offset_flipped;
  logic [7:0]        orient_normal;
  logic [7:0]        orient_flipped;

  logic [PixW-1:0] pixels_left;
  logic [PixW-1:0] pixels_left_next;
  logic            write_open;
  logic            write_open_next;
  logic            flip_state;
  logic            flip_state_next;

  logic            busy;
  logic [SeqW-1:0] seq;
  item_t           item;
  item_t           item_next;

  logic        in_accept;
  logic        out_free;
  logic        seq_last;
  logic [7:0]  byte_sel;
  logic        data_sel;
  logic        rel_sel;

  logic [CoordW-1:0] rect_x;
  logic [CoordW-1:0] rect_y;
  logic [CoordW-1:0] rect_w;
  logic [CoordW-1:0] rect_h;
  logic [15:0]       pixel_color;
  logic              flip;
  logic [CoordW-1:0] fw;
  logic [CoordW-1:0] fh;
  logic [CoordW-1:0] co;
  logic [CoordW-1:0] ro;
  logic              bad_rect;
  logic [2*CoordW-1:0] area;

  assign rect_x = s_tdata[8:0];
  assign rect_y = s_tdata[17:9];
  assign rect_w = s_tdata[26:18];
  assign rect_h = s_tdata[35:27];
  assign pixel_color = s_tdata[51:36];
  assign flip = s_tdata[52];

  assign cfg_ready = 1'b1;
  assign out_free = !m_tvalid || m_tready;
  assign seq_last = (seq == item.last_seq);
  assign s_tready = !busy || (out_free && seq_last);
  assign in_accept = s_tvalid && s_tready;

  assign fw = (DimW'(frame_width) > DimW'(MAX_DIM)) ? CoordW'(MAX_DIM) : frame_width;
  assign fh = (DimW'(frame_height) > DimW'(MAX_DIM)) ? CoordW'(MAX_DIM) : frame_height;
  assign co = flip_state ? col_offset_flipped : col_offset_normal;
  assign ro = flip_state ? row_offset_flipped : row_offset_normal;
  assign bad_rect = (rect_w == '0) || (rect_h == '0) || (rect_x >= fw) || (rect_y >= fh) ||
                    (rect_w > fw - rect_x) || (rect_h > fh - rect_y);
  assign area = (2*CoordW)'(rect_w) * (2*CoordW)'(rect_h);

  always_comb begin
    item_next = '0;
    item_next.kind = KIND_STATUS;
    item_next.last_seq = SEQ_FIRST;
    item_next.status = ST_OK;
    item_next.col_start = AddrW'(rect_x) + AddrW'(co);
    item_next.col_end = item_next.col_start + AddrW'(rect_w) - AddrW'(1);
    item_next.row_start = AddrW'(rect_y) + AddrW'(ro);
    item_next.row_end = item_next.row_start + AddrW'(rect_h) - AddrW'(1);
    item_next.color = pixel_color;
    item_next.done = (pixels_left == PixW'(1));
    item_next.orient = flip ? orient_flipped : orient_normal;
    pixels_left_next = pixels_left;
    write_open_next = write_open;
    flip_state_next = flip_state;
    case (s_tuser)
      OP_RECT: begin
        if (write_open) begin
          item_next.status = ST_WRITE_OPEN;
        end else if (bad_rect) begin
          item_next.status = ST_BAD_RECT;
        end else begin
          item_next.kind = KIND_RECT;
          item_next.last_seq = SEQ_MEMWRITE;
          pixels_left_next = PixW'(area);
          write_open_next = 1'b1;
        end
      end
      OP_PIXEL: begin
        if (!write_open) begin
          item_next.status = ST_NO_WRITE;
        end else begin
          item_next.kind = KIND_PIXEL;
          item_next.last_seq = SEQ_SECOND;
          pixels_left_next = pixels_left - PixW'(1);
          write_open_next = !item_next.done;
        end
      end
      OP_FLIP: begin
        if (write_open) begin
          item_next.status = ST_WRITE_OPEN;
        end else begin
          item_next.kind = KIND_FLIP;
          item_next.last_seq = SEQ_SECOND;
          flip_state_next = flip;
        end
      end
      default: begin
        item_next.kind = KIND_STATUS;
      end
    endcase
  end

  always_comb begin
    byte_sel = '0;
    data_sel = 1'b1;
    rel_sel = 1'b0;
    case (item.kind)
      KIND_RECT: begin
        case (seq)
          SEQ_COL_CMD: begin
            byte_sel = CMD_COLUMN;
            data_sel = 1'b0;
          end
          SEQ_COL_S_HI: byte_sel = 8'(item.col_start >> 8);
          SEQ_COL_S_LO: byte_sel = item.col_start[7:0];
          SEQ_COL_E_HI: byte_sel = 8'(item.col_end >> 8);
          SEQ_COL_E_LO: begin
            byte_sel = item.col_end[7:0];
            rel_sel = 1'b1;
          end
          SEQ_ROW_CMD: begin
            byte_sel = CMD_ROW;
            data_sel = 1'b0;
          end
          SEQ_ROW_S_HI: byte_sel = 8'(item.row_start >> 8);
          SEQ_ROW_S_LO: byte_sel = item.row_start[7:0];
          SEQ_ROW_E_HI: byte_sel = 8'(item.row_end >> 8);
          SEQ_ROW_E_LO: begin
            byte_sel = item.row_end[7:0];
            rel_sel = 1'b1;
          end
          default: begin
            byte_sel = CMD_MEMWRITE;
            data_sel = 1'b0;
          end
        endcase
      end
      KIND_PIXEL: begin
        byte_sel = seq_last ? (item.color[7:0] & BYTE_MASK) : item.color[15:8];
        rel_sel = seq_last && item.done;
      end
      KIND_FLIP: begin
        byte_sel = seq_last ? item.orient : CMD_ORIENT;
        data_sel = seq_last;
        rel_sel = seq_last;
      end
      default: begin
        data_sel = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      seq <= SEQ_FIRST;
      m_tvalid <= 1'b0;
      pixels_left <= '0;
      write_open <= 1'b0;
      flip_state <= 1'b0;
    end else begin
      if (out_free) begin
        m_tvalid <= busy;
      end
      if (in_accept) begin
        busy <= s_tuser inside {OP_RECT, OP_PIXEL, OP_FLIP};
        seq <= SEQ_FIRST;
        pixels_left <= pixels_left_next;
        write_open <= write_open_next;
        flip_state <= flip_state_next;
      end else begin
        if (out_free && busy) begin
          seq <= seq + SeqW'(1);
        end
        if (out_free && busy && seq_last) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      item <= item_next;
    end
    if (out_free && busy) begin
      m_tdata <= {6'b0, item.status, byte_sel};
      m_tuser <= {rel_sel, item.kind != KIND_STATUS, data_sel};
      m_tlast <= seq_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width <= 9'd240;
      frame_height <= 9'd320;
      col_offset_normal <= '0;
      row_offset_normal <= '0;
      col_offset_flipped <= '0;
      row_offset_flipped <= '0;
      orient_normal <= '0;
      orient_flipped <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_FRAME_WIDTH: frame_width <= cfg_data;
        REG_FRAME_HEIGHT: frame_height <= cfg_data;
        REG_COL_OFS_NORMAL: col_offset_normal <= cfg_data;
        REG_ROW_OFS_NORMAL: row_offset_normal <= cfg_data;
        REG_COL_OFS_FLIPPED: col_offset_flipped <= cfg_data;
        REG_ROW_OFS_FLIPPED: row_offset_flipped <= cfg_data;
        REG_ORIENT_NORMAL: orient_normal <= cfg_data[7:0];
        REG_ORIENT_FLIPPED: orient_flipped <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

endmodule

>>> hdl/dwwf_checker.sv
// Port checker for the display window write framer and its bind to the top level.
module dwwf_checker
  import dwwf_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [55:0] s_tdata,
  input logic [1:0]  s_tuser,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata,
  input logic [2:0]  m_tuser,
  input logic        m_tlast,
  input logic        cfg_valid,
  input logic        cfg_ready,
  input logic [3:0]  cfg_index,
  input logic [8:0]  cfg_data
);

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser) &&
    $stable(m_tlast))
    else $error("output transaction changed while stalled");

  a_reset_quiet: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid right after reset");

  a_status_only: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[1] |-> m_tlast && (m_tdata[7:0] == 8'h00) && !m_tuser[0] &&
    !m_tuser[2] && (m_tdata[9:8] != ST_OK))
    else $error("malformed status-only transaction");

  a_memwrite_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[1] && !m_tuser[0] && (m_tdata[7:0] == CMD_MEMWRITE) |->
    m_tlast && !m_tuser[2])
    else $error("memory write command is not the last byte of its item");

  a_release_on_data: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[2] |-> m_tuser[0] && m_tuser[1] && (m_tdata[9:8] == ST_OK))
    else $error("panel release on a byte that is not data");

endmodule

bind display_window_write_framer dwwf_checker u_dwwf_checker (.*);

>>> tb/display_window_write_framer_tb.sv
// Self-checking testbench for the display window write framer with a built-in byte predictor.
module display_window_write_framer_tb
  import dwwf_pkg::*;
;

  localparam int PanelMax = 320;
  localparam int CycleLimit = 400000;
  localparam int SettleCycles = 32;
  localparam logic [1:0] OpUnused = 2'd3;

  typedef struct packed {
    logic [1:0]  op;
    logic [8:0]  x;
    logic [8:0]  y;
    logic [8:0]  w;
    logic [8:0]  h;
    logic [15:0] color;
    logic        flip;
    logic        drain_first;
  } panel_cmd_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       is_data;
    logic       has_byte;
    logic       release_panel;
    logic       run_last;
    logic [1:0] status;
  } panel_byte_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [55:0] s_tdata = '0;
  logic [1:0]  s_tuser = OP_RECT;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;
  logic [2:0]  m_tuser;
  logic        m_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [3:0]  cfg_index = REG_FRAME_WIDTH;
  logic [8:0]  cfg_data = '0;

  panel_cmd_t  cmd_q[$];
  panel_byte_t panel_bytes_q[$];
  panel_cmd_t  cur_cmd;

  logic [8:0]  reg_val [0:7] = '{9'd240, 9'd320, 9'd0, 9'd0, 9'd0, 9'd0, 9'd0, 9'd0};
  logic [16:0] pixels_owed = '0;
  logic        write_open = 1'b0;
  logic        flipped = 1'b0;

  int send_gap = 0;
  int rx_stall = 0;
  bit tx_gaps_on = 1'b1;
  bit rx_gaps_on = 1'b1;
  bit rx_hold_req = 1'b0;
  int mismatches = 0;
  int cycle_count = 0;
  int phase_items = 0;

  display_window_write_framer DUT (.*);

  always #4 clk = ~clk;

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic int sat_dim(input logic [8:0] v);
    return (v > PanelMax) ? PanelMax : int'(v);
  endfunction

  task automatic expect_byte(input logic [7:0] b, input logic data, input logic has,
                             input logic rel, input logic last, input logic [1:0] st);
    panel_byte_t r;
    r.out_byte = b;
    r.is_data = data;
    r.has_byte = has;
    r.release_panel = rel;
    r.run_last = last;
    r.status = st;
    panel_bytes_q.push_back(r);
  endtask

  task automatic expect_window(input logic [7:0] cmd, input int start, input int len);
    logic [15:0] s;
    logic [15:0] e;
    s = 16'(start);
    e = 16'(int'(s) + len - 1);
    expect_byte(cmd, 1'b0, 1'b1, 1'b0, 1'b0, ST_OK);
    expect_byte(s[15:8], 1'b1, 1'b1, 1'b0, 1'b0, ST_OK);
    expect_byte(s[7:0], 1'b1, 1'b1, 1'b0, 1'b0, ST_OK);
    expect_byte(e[15:8], 1'b1, 1'b1, 1'b0, 1'b0, ST_OK);
    expect_byte(e[7:0], 1'b1, 1'b1, 1'b1, 1'b0, ST_OK);
  endtask

  task automatic frame_cmd(input panel_cmd_t c);
    int fw, fh, x, y, w, h, co, ro;
    logic done;
    fw = sat_dim(reg_val[REG_FRAME_WIDTH]);
    fh = sat_dim(reg_val[REG_FRAME_HEIGHT]);
    x = int'(c.x);
    y = int'(c.y);
    w = int'(c.w);
    h = int'(c.h);
    case (c.op)
      OP_RECT: begin
        if (write_open) begin
          expect_byte(8'h00, 1'b0, 1'b0, 1'b0, 1'b1, ST_WRITE_OPEN);
        end else if (w == 0 || h == 0 || x >= fw || y >= fh || w > fw - x || h > fh - y) begin
          expect_byte(8'h00, 1'b0, 1'b0, 1'b0, 1'b1, ST_BAD_RECT);
        end else begin
          co = flipped ? int'(reg_val[REG_COL_OFS_FLIPPED]) : int'(reg_val[REG_COL_OFS_NORMAL]);
          ro = flipped ? int'(reg_val[REG_ROW_OFS_FLIPPED]) : int'(reg_val[REG_ROW_OFS_NORMAL]);
          expect_window(CMD_COLUMN, x + co, w);
          expect_window(CMD_ROW, y + ro, h);
          expect_byte(CMD_MEMWRITE, 1'b0, 1'b1, 1'b0, 1'b1, ST_OK);
          pixels_owed = 17'(w * h);
          write_open = 1'b1;
        end
      end
      OP_PIXEL: begin
        if (!write_open) begin
          expect_byte(8'h00, 1'b0, 1'b0, 1'b0, 1'b1, ST_NO_WRITE);
        end else begin
          pixels_owed = pixels_owed - 17'd1;
          done = (pixels_owed == '0);
          if (done) write_open = 1'b0;
          expect_byte(c.color[15:8], 1'b1, 1'b1, 1'b0, 1'b0, ST_OK);
          expect_byte(c.color[7:0], 1'b1, 1'b1, done, 1'b1, ST_OK);
        end
      end
      OP_FLIP: begin
        if (write_open) begin
          expect_byte(8'h00, 1'b0, 1'b0, 1'b0, 1'b1, ST_WRITE_OPEN);
        end else begin
          flipped = c.flip;
          expect_byte(CMD_ORIENT, 1'b0, 1'b1, 1'b0, 1'b0, ST_OK);
          expect_byte(flipped ? reg_val[REG_ORIENT_FLIPPED][7:0] : reg_val[REG_ORIENT_NORMAL][7:0],
                      1'b1, 1'b1, 1'b1, 1'b1, ST_OK);
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    logic load;
    load = 1'b0;
    if (rst) begin
      s_tvalid <= 1'b0;
      send_gap = 0;
    end else begin
      if (s_tvalid && s_tready) frame_cmd(cur_cmd);
      if (!s_tvalid || s_tready) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (cmd_q.size() != 0 &&
                     !(cmd_q[0].drain_first && panel_bytes_q.size() != 0)) begin
          cur_cmd = cmd_q.pop_front();
          load = 1'b1;
          send_gap = tx_gaps_on ? idle_len() : 0;
          s_tdata <= {3'b000, cur_cmd.flip, cur_cmd.color, cur_cmd.h, cur_cmd.w,
                      cur_cmd.y, cur_cmd.x};
          s_tuser <= cur_cmd.op;
        end
        s_tvalid <= load;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      rx_stall = 0;
    end else if (rx_hold_req) begin
      rx_hold_req = 1'b0;
      rx_stall = 400;
      m_tready <= 1'b0;
    end else if (rx_stall > 0) begin
      rx_stall--;
      m_tready <= 1'b0;
    end else begin
      rx_stall = rx_gaps_on ? idle_len() : 0;
      m_tready <= (rx_stall == 0);
      if (rx_stall > 0) rx_stall--;
    end
  end

  always @(posedge clk) begin
    panel_byte_t got;
    panel_byte_t want;
    if (!rst && m_tvalid && m_tready) begin
      got.out_byte = m_tdata[7:0];
      got.status = m_tdata[9:8];
      got.is_data = m_tuser[0];
      got.has_byte = m_tuser[1];
      got.release_panel = m_tuser[2];
      got.run_last = m_tlast;
      if (panel_bytes_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("cycle %0d: unexpected byte %h data %b has %b rel %b last %b st %0d",
                   cycle_count, got.out_byte, got.is_data, got.has_byte, got.release_panel,
                   got.run_last, got.status);
      end else begin
        want = panel_bytes_q.pop_front();
        if (got.out_byte !== want.out_byte || got.is_data !== want.is_data ||
            got.has_byte !== want.has_byte || got.release_panel !== want.release_panel ||
            got.run_last !== want.run_last || got.status !== want.status) begin
          mismatches++;
          if (mismatches <= 10) begin
            $write("cycle %0d: expected byte %h data %b has %b rel %b last %b st %0d, ",
                   cycle_count, want.out_byte, want.is_data, want.has_byte,
                   want.release_panel, want.run_last, want.status);
            $display("got byte %h data %b has %b rel %b last %b st %0d",
                     got.out_byte, got.is_data, got.has_byte, got.release_panel,
                     got.run_last, got.status);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("display_window_write_framer: mismatch");
      $finish;
    end
  end

  task automatic write_reg(input logic [3:0] idx, input logic [8:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx <= REG_ORIENT_FLIPPED)
      reg_val[idx] = (idx >= REG_ORIENT_NORMAL) ? {1'b0, val[7:0]} : val;
  endtask

  task automatic set_panel(input logic [8:0] fw, input logic [8:0] fh,
                           input logic [8:0] col_n, input logic [8:0] row_n,
                           input logic [8:0] col_f, input logic [8:0] row_f,
                           input logic [8:0] or_n, input logic [8:0] or_f);
    write_reg(REG_FRAME_WIDTH, fw);
    write_reg(REG_FRAME_HEIGHT, fh);
    write_reg(REG_COL_OFS_NORMAL, col_n);
    write_reg(REG_ROW_OFS_NORMAL, row_n);
    write_reg(REG_COL_OFS_FLIPPED, col_f);
    write_reg(REG_ROW_OFS_FLIPPED, row_f);
    write_reg(REG_ORIENT_NORMAL, or_n);
    write_reg(REG_ORIENT_FLIPPED, or_f);
    write_reg(4'($urandom_range(REG_ORIENT_FLIPPED + 1, 15)), 9'($urandom));
  endtask

  task automatic wait_idle();
    while (cmd_q.size() != 0 || s_tvalid || panel_bytes_q.size() != 0) @(negedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  function automatic panel_cmd_t any_cmd(input logic [1:0] op);
    panel_cmd_t c;
    c.op = op;
    c.x = 9'($urandom);
    c.y = 9'($urandom);
    c.w = 9'($urandom);
    c.h = 9'($urandom);
    c.color = 16'($urandom);
    c.flip = 1'($urandom);
    c.drain_first = 1'b0;
    return c;
  endfunction

  task automatic push_cmd(input panel_cmd_t c);
    cmd_q.push_back(c);
    if (c.op != OpUnused) phase_items++;
  endtask

  task automatic push_rect(input int x, input int y, input int w, input int h);
    panel_cmd_t c;
    c = any_cmd(OP_RECT);
    c.x = 9'(x);
    c.y = 9'(y);
    c.w = 9'(w);
    c.h = 9'(h);
    push_cmd(c);
  endtask

  task automatic push_pixel(input logic [15:0] color);
    panel_cmd_t c;
    c = any_cmd(OP_PIXEL);
    c.color = color;
    push_cmd(c);
  endtask

  task automatic push_flip(input logic f, input logic drain);
    panel_cmd_t c;
    c = any_cmd(OP_FLIP);
    c.flip = f;
    c.drain_first = drain;
    push_cmd(c);
  endtask

  task automatic push_bad_rect(input int fw, input int fh);
    panel_cmd_t c;
    c = any_cmd(OP_RECT);
    case ($urandom_range(0, 4))
      0: c.w = '0;
      1: c.h = '0;
      2: c.x = 9'($urandom_range(fw, 511));
      3: c.y = 9'($urandom_range(fh, 511));
      default: begin
        if (fw > 0) begin
          c.x = 9'($urandom_range(0, fw - 1));
          c.w = 9'($urandom_range(fw - int'(c.x) + 1, 511));
        end
      end
    endcase
    push_cmd(c);
  endtask

  task automatic push_open_noise();
    case ($urandom_range(0, 2))
      0: push_cmd(any_cmd(OP_RECT));
      1: push_cmd(any_cmd(OP_FLIP));
      default: push_cmd(any_cmd(OpUnused));
    endcase
  endtask

  task automatic add_burst();
    panel_cmd_t c;
    int fw, fh, x, y, w, h, n;
    fw = sat_dim(reg_val[REG_FRAME_WIDTH]);
    fh = sat_dim(reg_val[REG_FRAME_HEIGHT]);
    case ($urandom_range(0, 9))
      0: push_pixel(16'($urandom));
      1: push_bad_rect(fw, fh);
      2: push_cmd(any_cmd(OpUnused));
      3: push_cmd(any_cmd(OP_FLIP));
      default: begin
        if (fw == 0 || fh == 0) begin
          push_bad_rect(fw, fh);
        end else begin
          x = ($urandom_range(0, 2) == 0) ? fw - 1 : $urandom_range(0, fw - 1);
          y = ($urandom_range(0, 2) == 0) ? fh - 1 : $urandom_range(0, fh - 1);
          w = $urandom_range(1, (fw - x < 4) ? fw - x : 4);
          h = $urandom_range(1, (fh - y < 3) ? fh - y : 3);
          c = any_cmd(OP_RECT);
          c.x = 9'(x);
          c.y = 9'(y);
          c.w = 9'(w);
          c.h = 9'(h);
          c.drain_first = ($urandom_range(0, 7) == 0);
          push_cmd(c);
          for (n = 0; n < w * h; n++) begin
            if ($urandom_range(0, 11) == 0) push_open_noise();
            push_pixel(16'($urandom));
          end
        end
      end
    endcase
  endtask

  task automatic random_phase(input int n);
    phase_items = 0;
    while (phase_items < n) add_burst();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed pass on the reset register values.
    push_pixel(16'h1234);
    push_flip(1'b1, 1'b0);
    push_flip(1'b0, 1'b0);
    push_cmd(any_cmd(OpUnused));
    push_rect(5, 5, 0, 3);
    push_rect(5, 5, 3, 0);
    push_rect(240, 0, 1, 1);
    push_rect(0, 320, 1, 1);
    push_rect(200, 10, 41, 1);
    push_rect(10, 300, 1, 21);
    push_rect(511, 511, 511, 511);
    push_rect(239, 319, 1, 1);
    push_rect(0, 0, 1, 1);
    push_flip(1'b1, 1'b0);
    push_cmd(any_cmd(OpUnused));
    push_pixel(16'hFFFF);
    push_rect(0, 0, 2, 1);
    push_pixel(16'h0000);
    push_pixel(16'hA5C3);
    wait_idle();

    // Full panel with offsets up to 319; the receiver holds off while pixels keep coming.
    set_panel(9'd320, 9'd320, 9'd319, 9'd319, 9'd256, 9'd255, 9'h1A5, 9'h0FF);
    push_flip(1'b0, 1'b0);
    tx_gaps_on = 1'b0;
    push_rect(316, 0, 4, 1);
    repeat (4) push_pixel(16'($urandom));
    rx_hold_req = 1'b1;
    push_flip(1'b1, 1'b1);
    push_rect(319, 316, 1, 4);
    repeat (4) push_pixel(16'($urandom));
    while (cmd_q.size() != 0) @(posedge clk);
    tx_gaps_on = 1'b1;
    random_phase(15);
    wait_idle();

    set_panel(9'd1, 9'd1, 9'd0, 9'd0, 9'd511, 9'd511, 9'd0, 9'd255);
    random_phase(12);
    wait_idle();

    set_panel(9'd511, 9'd321, 9'($urandom_range(0, 319)), 9'($urandom_range(0, 319)),
              9'($urandom_range(0, 319)), 9'($urandom_range(0, 319)), 9'($urandom),
              9'($urandom));
    random_phase(15);
    wait_idle();

    set_panel(9'd0, 9'($urandom_range(0, 511)), 9'($urandom), 9'($urandom), 9'($urandom),
              9'($urandom), 9'($urandom), 9'($urandom));
    random_phase(6);
    wait_idle();

    set_panel(9'($urandom_range(1, PanelMax)), 9'($urandom_range(1, PanelMax)),
              9'($urandom_range(0, 319)), 9'($urandom_range(0, 319)),
              9'($urandom_range(0, 319)), 9'($urandom_range(0, 319)), 9'($urandom),
              9'($urandom));
    tx_gaps_on = 1'b0;
    rx_gaps_on = 1'b0;
    random_phase(15);
    wait_idle();

    if (mismatches == 0) begin
      $display("display_window_write_framer: match");
    end else begin
      $display("display_window_write_framer: mismatch");
    end
    $finish;
  end

endmodule
